// File: hdl/tdr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdr_pkg
// Types, sizes and codes shared by the transmit descriptor ring modules.
// ----------------------------------------------------------------------------
package tdr_pkg;

  localparam int RING_SLOTS  = 512;
  localparam int CLEAN_BATCH = 32;

  localparam int SLOT_W  = $clog2(RING_SLOTS);
  localparam int CNT_W   = $clog2(RING_SLOTS + 1);
  localparam int BATCH_W = $clog2(CLEAN_BATCH + 1);

  // request types
  localparam logic [1:0] REQ_TX    = 2'd0;
  localparam logic [1:0] REQ_WB    = 2'd1;
  localparam logic [1:0] REQ_CLEAN = 2'd2;

  // result status codes
  localparam logic [2:0] ST_QUEUED  = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_FREED   = 3'd2;
  localparam logic [2:0] ST_NOCLEAN = 3'd3;
  localparam logic [2:0] ST_WB_ACK  = 3'd4;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [47:0] buf_addr;
    logic [13:0] pkt_len;
    logic [15:0] buf_handle;
    logic [8:0]  done_slot;
  } tdr_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [8:0]  slot;
    logic [47:0] desc_addr;
    logic [13:0] desc_len;
    logic [8:0]  tail;
    logic [15:0] freed_handle;
    logic        last;
  } tdr_rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic do_tx;       // process transmit request on the input port
    logic do_wb;       // process writeback request on the input port
    logic clean_rd;    // read done mark at end of batch
    logic commit;      // advance clean index, set up free walk
    logic emit_none;   // load a nothing-cleaned result
    logic handle_rd;   // read handle at current free slot
    logic emit_freed;  // load a freed result and step the walk
  } tdr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
    logic clean_ok;
    logic n_zero;
    logic free_last;
  } tdr_stat_t;

endpackage

// File: hdl/tdr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdr_ctrl
// Sequencer: takes requests and steps the batch clean walk.
// ----------------------------------------------------------------------------
module tdr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic [1:0]        req_type,
  output logic              req_ready,
  input  tdr_pkg::tdr_stat_t stat,
  output tdr_pkg::tdr_cmd_t  cmd
);
  import tdr_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CHK  = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       take;

  assign req_ready = (state == S_IDLE) && stat.out_free;
  assign take      = req_valid && req_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (take) begin
          case (req_type)
            REQ_TX:    cmd.do_tx = 1'b1;
            REQ_WB:    cmd.do_wb = 1'b1;
            REQ_CLEAN: begin
              cmd.clean_rd = 1'b1;
              state_next   = S_CHK;
            end
            default: ;
          endcase
        end
      end
      S_CHK: begin
        if (stat.clean_ok && !stat.n_zero) begin
          cmd.commit = 1'b1;
          state_next = S_RD;
        end else if (stat.out_free) begin
          cmd.emit_none = 1'b1;
          cmd.commit    = stat.clean_ok;
          state_next    = S_IDLE;
        end
      end
      S_RD: begin
        cmd.handle_rd = 1'b1;
        state_next    = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.emit_freed = 1'b1;
          state_next     = stat.free_last ? S_IDLE : S_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: hdl/tdr_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdr_dp
// Ring indices, done-mark and handle memories, and the result register.
// ----------------------------------------------------------------------------
module tdr_dp (
  input  logic               clk,
  input  logic               rst,
  input  tdr_pkg::tdr_req_t  req,
  input  tdr_pkg::tdr_cmd_t  cmd,
  output tdr_pkg::tdr_stat_t stat,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output tdr_pkg::tdr_rsp_t  rsp
);
  import tdr_pkg::*;

  logic [SLOT_W-1:0]  tail_slot;
  logic [SLOT_W-1:0]  clean_slot;
  logic [CNT_W-1:0]   pending_count;
  logic [SLOT_W-1:0]  free_slot;
  logic [BATCH_W-1:0] free_left;

  logic               done_mem [RING_SLOTS];
  logic [15:0]        handle_mem [RING_SLOTS];
  logic               done_q;
  logic [15:0]        handle_q;

  logic [SLOT_W-1:0]  tail_inc;
  logic               full;
  logic [SLOT_W-1:0]  wb_slot;
  logic [SLOT_W-1:0]  outstanding;
  logic [SLOT_W-1:0]  batch_end;
  logic [BATCH_W-1:0] n_free;
  logic [SLOT_W-1:0]  head;
  logic               done_we;
  logic [SLOT_W-1:0]  done_addr;
  logic               tx_go;
  tdr_rsp_t           rsp_next;
  logic               load;

  assign tail_inc    = tail_slot + SLOT_W'(1);
  assign full        = (tail_inc == clean_slot);
  assign tx_go       = cmd.do_tx && !full;
  assign wb_slot     = SLOT_W'(req.done_slot);
  assign outstanding = tail_slot - clean_slot;
  assign batch_end   = clean_slot + SLOT_W'(CLEAN_BATCH - 1);
  assign n_free      = (pending_count < CNT_W'(CLEAN_BATCH)) ?
                       BATCH_W'(pending_count) : BATCH_W'(CLEAN_BATCH);
  assign head        = tail_slot - pending_count[SLOT_W-1:0];

  assign stat.out_free  = !rsp_valid || rsp_ready;
  assign stat.clean_ok  = ({1'b0, outstanding} >= CNT_W'(CLEAN_BATCH)) && done_q;
  assign stat.n_zero    = (n_free == '0);
  assign stat.free_last = (free_left == BATCH_W'(1));

  // done marks: cleared by transmit, set by writeback
  assign done_we   = tx_go || cmd.do_wb;
  assign done_addr = cmd.do_wb ? wb_slot : tail_slot;

  always_ff @(posedge clk) begin
    if (done_we) begin
      done_mem[done_addr] <= cmd.do_wb;
    end
    if (cmd.clean_rd) begin
      done_q <= done_mem[batch_end];
    end
  end

  always_ff @(posedge clk) begin
    if (tx_go) begin
      handle_mem[tail_slot] <= req.buf_handle;
    end
    if (cmd.handle_rd) begin
      handle_q <= handle_mem[free_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tail_slot     <= '0;
      clean_slot    <= '0;
      pending_count <= '0;
    end else begin
      if (tx_go) begin
        tail_slot <= tail_inc;
        if (pending_count < CNT_W'(RING_SLOTS)) begin
          pending_count <= pending_count + CNT_W'(1);
        end
      end else if (cmd.commit) begin
        pending_count <= pending_count - CNT_W'(n_free);
        clean_slot    <= batch_end + SLOT_W'(1);
      end
    end
  end

  // free walk position
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      free_slot <= head;
      free_left <= n_free;
    end else if (cmd.emit_freed) begin
      free_slot <= free_slot + SLOT_W'(1);
      free_left <= free_left - BATCH_W'(1);
    end
  end

  always_comb begin
    rsp_next      = '0;
    rsp_next.tail = 9'(tail_slot);
    rsp_next.last = 1'b1;
    load          = 1'b0;
    if (cmd.do_tx) begin
      load = 1'b1;
      if (full) begin
        rsp_next.status = ST_FULL;
      end else begin
        rsp_next.status    = ST_QUEUED;
        rsp_next.slot      = 9'(tail_slot);
        rsp_next.desc_addr = req.buf_addr;
        rsp_next.desc_len  = req.pkt_len;
        rsp_next.tail      = 9'(tail_inc);
      end
    end else if (cmd.do_wb) begin
      load            = 1'b1;
      rsp_next.status = ST_WB_ACK;
      rsp_next.slot   = 9'(wb_slot);
    end else if (cmd.emit_none) begin
      load            = 1'b1;
      rsp_next.status = ST_NOCLEAN;
    end else if (cmd.emit_freed) begin
      load                  = 1'b1;
      rsp_next.status       = ST_FREED;
      rsp_next.slot         = 9'(free_slot);
      rsp_next.freed_handle = handle_q;
      rsp_next.last         = stat.free_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp <= rsp_next;
    end
  end

endmodule

// File: hdl/tx_descriptor_ring_with_batch_clean_core.sv
`timescale 1ns / 1ps
// Transmit and writeback requests load a registered result that shows the cycle after
// the transfer; the input stalls while a result waits untaken or a clean is running.
// A clean request reads and checks the done mark at the batch end, then for each freed
// handle reads the handle memory and loads the result register, up to 32 per clean.
// Reset clears tail, clean index and pending count; the done-mark memory is not swept,
// since a slot's transmit always clears its mark before a clean can read it.
// ----------------------------------------------------------------------------
// tx_descriptor_ring_with_batch_clean_core
// Transmit descriptor ring producer with batched buffer clean-up.
// ----------------------------------------------------------------------------
module tx_descriptor_ring_with_batch_clean_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  tdr_pkg::tdr_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output tdr_pkg::tdr_rsp_t rsp
);
  import tdr_pkg::*;

  tdr_cmd_t  cmd;
  tdr_stat_t stat;

  tdr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_type  (req.req_type),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tdr_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
